// ===== src/ari_pkg.sv =====
// Shared types, constants and command/status records for the adjusted Rand index block.
package ari_pkg;

    localparam int DEF_CLUSTERS_A = 16;
    localparam int DEF_CLUSTERS_B = 16;
    localparam int DEF_COUNT_BITS = 16;

    localparam int LABEL_W    = 4;
    localparam int OUT_W      = 18;
    localparam int PAIR_OUT_W = 31;
    localparam int FRAC_BITS  = 16;
    localparam int MUL_DIGIT  = 16;

    // product selects for the shared multiplier
    localparam logic [1:0] MUL_T1T4  = 2'd0;
    localparam logic [1:0] MUL_T2T3  = 2'd1;
    localparam logic [1:0] MUL_SUMT4 = 2'd2;

    // walk item kinds
    localparam logic [1:0] TAG_CELL  = 2'd0;
    localparam logic [1:0] TAG_ROW   = 2'd1;
    localparam logic [1:0] TAG_COL   = 2'd2;
    localparam logic [1:0] TAG_TOTAL = 2'd3;

    typedef struct packed {
        logic [LABEL_W-1:0] label_a;
        logic [LABEL_W-1:0] label_b;
        logic               last;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] index_q16;
        logic [PAIR_OUT_W-1:0]   agree_pairs;
        logic [PAIR_OUT_W-1:0]   row_pairs;
        logic [PAIR_OUT_W-1:0]   col_pairs;
        logic                    zero_denominator;
        logic                    count_overflow;
    } t_out;

    typedef struct packed {
        logic       load;
        logic       store;
        logic       walk_init;
        logic       walk_run;
        logic       mul_init;
        logic [1:0] mul_sel;
        logic       mul_run;
        logic       div_init;
        logic       div_run;
        logic       finish;
    } t_cmd;

    typedef struct packed {
        logic last_item;
        logic walk_done;
        logic mul_done;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

// ===== src/ari_dpath.sv =====
// Datapath: contingency memory, totals, pair-count walk, shared multiplier, divider, result register.
module ari_dpath #(
    parameter int CLUSTERS_A = ari_pkg::DEF_CLUSTERS_A,
    parameter int CLUSTERS_B = ari_pkg::DEF_CLUSTERS_B,
    parameter int COUNT_BITS = ari_pkg::DEF_COUNT_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ari_pkg::t_in  i_in,
    input  ari_pkg::t_cmd i_cmd,
    output ari_pkg::t_stat o_stat,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output ari_pkg::t_out o_out
);
    import ari_pkg::*;

    localparam int LABEL_N = 1 << LABEL_W;
    localparam int ROWS    = (CLUSTERS_A < LABEL_N) ? CLUSTERS_A : LABEL_N;
    localparam int COLS    = (CLUSTERS_B < LABEL_N) ? CLUSTERS_B : LABEL_N;
    localparam int ROW_W   = $clog2(ROWS);
    localparam int COL_W   = $clog2(COLS);
    localparam int CELL_AW = ROW_W + COL_W;
    localparam int CELL_N  = 1 << CELL_AW;
    localparam int CB      = COUNT_BITS;
    localparam int PW      = 2 * CB - 1;
    localparam int MW      = 2 * PW + 1;
    localparam int ND      = (PW + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int MB_W    = ND * MUL_DIGIT;
    localparam int MC_W    = $clog2(ND + 1);
    localparam int WALK_N  = CELL_N + ROWS + COLS + 1;
    localparam int WK_W    = $clog2(WALK_N + 1);
    localparam int SHIFT   = FRAC_BITS + 1;
    localparam int DN_W    = MW + SHIFT;
    localparam int DV_W    = $clog2(DN_W + 1);
    localparam int QW      = OUT_W + 1;
    localparam int SW      = (PW > PAIR_OUT_W) ? PW : PAIR_OUT_W;

    // label saturation
    logic [LABEL_W:0] ext_a, ext_b;
    logic [ROW_W-1:0] row_in;
    logic [COL_W-1:0] col_in;
    assign ext_a  = {1'b0, i_in.label_a};
    assign ext_b  = {1'b0, i_in.label_b};
    assign row_in = (ext_a >= (LABEL_W+1)'(ROWS)) ? ROW_W'(ROWS - 1) : i_in.label_a[ROW_W-1:0];
    assign col_in = (ext_b >= (LABEL_W+1)'(COLS)) ? COL_W'(COLS - 1) : i_in.label_b[COL_W-1:0];

    // table memory and load registers
    logic [CB-1:0]      r_mem [CELL_N];
    logic [CB-1:0]      r_mem_q;
    logic               r_mem_vq;
    logic [CELL_N-1:0]  r_valid;
    logic [ROW_W-1:0]   r_ra;
    logic [COL_W-1:0]   r_ca;
    logic               r_last;
    logic               r_drop;
    logic [CB-1:0]      r_row_tot [ROWS];
    logic [CB-1:0]      r_col_tot [COLS];
    logic [CB-1:0]      r_count;
    logic               r_ovf;
    logic [CELL_AW-1:0] rd_addr;
    logic [CB-1:0]      cell_cur;
    logic               do_store;

    // walk registers
    logic [WK_W-1:0]  r_widx;
    logic             r_s1_v, r_s2_v;
    logic [1:0]       r_s1_tag, r_s2_tag;
    logic [CB-1:0]    r_aux_q;
    logic [2*CB-1:0]  r_prod;
    logic [PW-1:0]    r_t1, r_t2, r_t3, r_t4;
    logic             issue;
    logic [1:0]       w_tag;
    logic [WK_W-1:0]  w_off_r, w_off_c;
    logic [CB-1:0]    w_aux;
    logic [CB-1:0]    s1_val, s1_m1;
    logic [2*CB-1:0]  s1_prod;
    logic [PW-1:0]    s2_half;

    // multiplier registers
    logic [PW:0]      r_ma;
    logic [MB_W-1:0]  r_mb;
    logic [MC_W-1:0]  r_mcnt;
    logic [MW-1:0]    r_macc;
    logic [1:0]       r_msel;
    logic [MW-1:0]    r_p, r_q, r_r;
    logic [MUL_DIGIT-1:0]       digit;
    logic [PW+MUL_DIGIT:0]      pp;
    logic [MW-1:0]    n_macc;

    // divider registers
    logic [DN_W-1:0]  r_dnum;
    logic [MW-1:0]    r_den;
    logic [MW-1:0]    r_drem;
    logic [QW-1:0]    r_dq;
    logic             r_dsat;
    logic [DV_W-1:0]  r_dcnt;
    logic             r_neg;
    logic             r_zden;
    logic [MW-1:0]    num_mag, den_val;
    logic [MW:0]      rem2, diff;
    logic             ge;

    // result
    logic             r_ov;
    t_out             r_out;
    logic [QW-1:0]    mag;
    logic [OUT_W-1:0] idx_mag;
    logic [OUT_W-1:0] idx_val;

    function automatic logic [PAIR_OUT_W-1:0] sat31(input logic [PW-1:0] v);
        logic [SW-1:0] ext;
        ext = SW'(v);
        if (ext > SW'({PAIR_OUT_W{1'b1}})) begin
            return {PAIR_OUT_W{1'b1}};
        end
        return ext[PAIR_OUT_W-1:0];
    endfunction

    // ---------------- load ----------------
    assign rd_addr  = i_cmd.load ? {row_in, col_in} : r_widx[CELL_AW-1:0];
    assign cell_cur = r_mem_vq ? r_mem_q : '0;
    assign do_store = i_cmd.store && !r_drop;

    always_ff @(posedge i_clk) begin
        r_mem_q  <= r_mem[rd_addr];
        r_mem_vq <= r_valid[rd_addr];
        if (do_store) begin
            r_mem[{r_ra, r_ca}] <= cell_cur + CB'(1);
        end
        if (i_cmd.load) begin
            r_ra   <= row_in;
            r_ca   <= col_in;
            r_last <= i_in.last;
            r_drop <= (r_count == {CB{1'b1}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.finish) begin
            r_valid <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
            for (int i = 0; i < ROWS; i++) begin
                r_row_tot[i] <= '0;
            end
            for (int j = 0; j < COLS; j++) begin
                r_col_tot[j] <= '0;
            end
        end else if (i_cmd.store) begin
            if (r_drop) begin
                r_ovf <= 1'b1;
            end else begin
                r_valid[{r_ra, r_ca}] <= 1'b1;
                r_count               <= r_count + CB'(1);
                r_row_tot[r_ra]       <= r_row_tot[r_ra] + CB'(1);
                r_col_tot[r_ca]       <= r_col_tot[r_ca] + CB'(1);
            end
        end
    end

    // ---------------- walk ----------------
    assign issue   = i_cmd.walk_run && (r_widx != WK_W'(WALK_N));
    assign w_off_r = r_widx - WK_W'(CELL_N);
    assign w_off_c = r_widx - WK_W'(CELL_N + ROWS);

    always_comb begin
        if (r_widx < WK_W'(CELL_N)) begin
            w_tag = TAG_CELL;
        end else if (r_widx < WK_W'(CELL_N + ROWS)) begin
            w_tag = TAG_ROW;
        end else if (r_widx < WK_W'(CELL_N + ROWS + COLS)) begin
            w_tag = TAG_COL;
        end else begin
            w_tag = TAG_TOTAL;
        end
    end

    always_comb begin
        case (w_tag)
            TAG_ROW: w_aux = r_row_tot[w_off_r[ROW_W-1:0]];
            TAG_COL: w_aux = r_col_tot[w_off_c[COL_W-1:0]];
            default: w_aux = r_count;
        endcase
    end

    assign s1_val  = (r_s1_tag == TAG_CELL) ? cell_cur : r_aux_q;
    assign s1_m1   = s1_val - CB'(1);
    assign s1_prod = (2*CB)'(s1_val) * (2*CB)'(s1_m1);
    assign s2_half = r_prod[2*CB-1:1];

    always_ff @(posedge i_clk) begin
        r_aux_q  <= w_aux;
        r_s1_tag <= w_tag;
        r_s2_tag <= r_s1_tag;
        r_prod   <= s1_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widx <= '0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else if (i_cmd.walk_init) begin
            r_widx <= '0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= issue;
            r_s2_v <= r_s1_v;
            if (issue) begin
                r_widx <= r_widx + WK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_t1 <= '0;
            r_t2 <= '0;
            r_t3 <= '0;
            r_t4 <= '0;
        end else if (r_s2_v) begin
            case (r_s2_tag)
                TAG_CELL: r_t1 <= r_t1 + s2_half;
                TAG_ROW:  r_t2 <= r_t2 + s2_half;
                TAG_COL:  r_t3 <= r_t3 + s2_half;
                default:  r_t4 <= s2_half;
            endcase
        end
    end

    // ---------------- multiplier, one digit of b per cycle ----------------
    assign digit  = r_mb[MB_W-1 -: MUL_DIGIT];
    assign pp     = r_ma * digit;
    assign n_macc = (r_macc << MUL_DIGIT) + MW'(pp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcnt <= '0;
        end else if (i_cmd.mul_init) begin
            r_mcnt <= '0;
        end else if (i_cmd.mul_run && (r_mcnt != MC_W'(ND))) begin
            r_mcnt <= r_mcnt + MC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_init) begin
            r_macc <= '0;
            r_msel <= i_cmd.mul_sel;
            case (i_cmd.mul_sel)
                MUL_T1T4: begin
                    r_ma <= {1'b0, r_t1};
                    r_mb <= MB_W'(r_t4);
                end
                MUL_T2T3: begin
                    r_ma <= {1'b0, r_t2};
                    r_mb <= MB_W'(r_t3);
                end
                default: begin
                    r_ma <= {1'b0, r_t2} + {1'b0, r_t3};
                    r_mb <= MB_W'(r_t4);
                end
            endcase
        end else if (i_cmd.mul_run && (r_mcnt != MC_W'(ND))) begin
            r_macc <= n_macc;
            r_mb   <= r_mb << MUL_DIGIT;
            if (r_mcnt == MC_W'(ND - 1)) begin
                case (r_msel)
                    MUL_T1T4: r_p <= n_macc;
                    MUL_T2T3: r_q <= n_macc;
                    default:  r_r <= n_macc;
                endcase
            end
        end
    end

    // ---------------- restoring divider, one quotient bit per cycle ----------------
    assign num_mag = (r_p >= r_q) ? (r_p - r_q) : (r_q - r_p);
    assign den_val = r_r - (r_q << 1);
    assign rem2    = {r_drem, r_dnum[DN_W-1]};
    assign diff    = rem2 - {1'b0, r_den};
    assign ge      = (rem2 >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_init) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_run && (r_dcnt != DV_W'(DN_W))) begin
            r_dcnt <= r_dcnt + DV_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_dnum <= {num_mag, SHIFT'(0)};
            r_den  <= den_val;
            r_drem <= '0;
            r_dq   <= '0;
            r_dsat <= 1'b0;
            r_neg  <= (r_p < r_q);
            r_zden <= (den_val == '0);
        end else if (i_cmd.div_run && (r_dcnt != DV_W'(DN_W))) begin
            r_drem <= ge ? diff[MW-1:0] : rem2[MW-1:0];
            r_dnum <= r_dnum << 1;
            r_dq   <= {r_dq[QW-2:0], ge};
            r_dsat <= r_dsat | r_dq[QW-1];
        end
    end

    // ---------------- clamp and result register ----------------
    always_comb begin
        if (r_neg) begin
            mag = (r_dsat || (r_dq > QW'(1 << SHIFT))) ? QW'(1 << SHIFT) : r_dq;
        end else begin
            mag = (r_dsat || (r_dq > QW'(1 << FRAC_BITS))) ? QW'(1 << FRAC_BITS) : r_dq;
        end
    end
    assign idx_mag = mag[OUT_W-1:0];
    assign idx_val = r_zden ? '0 : (r_neg ? (OUT_W'(0) - idx_mag) : idx_mag);

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.index_q16        <= $signed(idx_val);
            r_out.agree_pairs      <= sat31(r_t1);
            r_out.row_pairs        <= sat31(r_t2);
            r_out.col_pairs        <= sat31(r_t3);
            r_out.zero_denominator <= r_zden;
            r_out.count_overflow   <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.finish) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_out_valid      = r_ov;
    assign o_out            = r_out;
    assign o_stat.last_item = r_last;
    assign o_stat.walk_done = (r_widx == WK_W'(WALK_N)) && !r_s1_v && !r_s2_v;
    assign o_stat.mul_done  = (r_mcnt == MC_W'(ND));
    assign o_stat.div_done  = (r_dcnt == DV_W'(DN_W));
    assign o_stat.out_free  = !r_ov || i_out_ready;

endmodule

// ===== src/ari_ctrl.sv =====
// Controller: sequences load, table walk, the three products, division and result hand-off.
module ari_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ari_pkg::t_stat i_stat,
    output ari_pkg::t_cmd  o_cmd
);
    import ari_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_STORE = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0] r_state, n_state;
    logic [1:0] r_sel, n_sel;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_STORE;
                end
            end
            S_STORE: begin
                cmd.store = 1'b1;
                if (i_stat.last_item) begin
                    cmd.walk_init = 1'b1;
                    n_state       = S_WALK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_WALK: begin
                if (i_stat.walk_done) begin
                    cmd.mul_init = 1'b1;
                    cmd.mul_sel  = MUL_T1T4;
                    n_sel        = MUL_T1T4;
                    n_state      = S_MUL;
                end else begin
                    cmd.walk_run = 1'b1;
                end
            end
            S_MUL: begin
                if (!i_stat.mul_done) begin
                    cmd.mul_run = 1'b1;
                end else if (r_sel == MUL_SUMT4) begin
                    cmd.div_init = 1'b1;
                    n_state      = S_DIV;
                end else begin
                    // advance to the next product
                    cmd.mul_init = 1'b1;
                    cmd.mul_sel  = r_sel + 2'd1;
                    n_sel        = r_sel + 2'd1;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_FIN;
                end else begin
                    cmd.div_run = 1'b1;
                end
            end
            S_FIN: begin
                // hold until the result register is free
                if (i_stat.out_free) begin
                    cmd.finish = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= MUL_T1T4;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

    a_load_then_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> (r_state == S_STORE))
        else $error("request load not followed by store");

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> i_stat.out_free)
        else $error("result written while output register busy");

    a_mul_guard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mul_run |-> !i_stat.mul_done)
        else $error("multiplier stepped past its last digit");

    a_div_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_init |-> (i_stat.mul_done && (r_sel == MUL_SUMT4)))
        else $error("division started before products complete");

endmodule

// ===== src/adjusted_rand_index.sv =====
// Top level of the adjusted Rand index block: controller plus datapath.
//
// Each request carries one pattern's labels in partitions A and B; a pattern's
// contingency cell in the table memory is read, then written back.
// On the pattern marked last the block walks every table cell, row total, column
// total and the pattern count through a 3-stage pair-count pipeline (A and B
// capped at 16), forms three products on a 16-bit-digit multiplier, then runs a
// one-bit-per-cycle divider. The table is cleared when the result is registered.
module adjusted_rand_index #(
    parameter int CLUSTERS_A = ari_pkg::DEF_CLUSTERS_A,
    parameter int CLUSTERS_B = ari_pkg::DEF_CLUSTERS_B,
    parameter int COUNT_BITS = ari_pkg::DEF_COUNT_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ari_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ari_pkg::t_out o_out
);
    import ari_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ari_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ari_dpath #(
        .CLUSTERS_A (CLUSTERS_A),
        .CLUSTERS_B (CLUSTERS_B),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the adjusted Rand index block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ari_pkg::*;

    localparam int NA = DEF_CLUSTERS_A;
    localparam int NB = DEF_CLUSTERS_B;
    localparam int CNT_MAX = (1 << DEF_COUNT_BITS) - 1;

    class ari_scoreboard;
        int unsigned cells[NA*NB];
        int unsigned rows[NA];
        int unsigned cols[NB];
        int unsigned n_pat;
        bit          ovf;
        t_out        pending[$];
        int          errors;
        int          sets_checked;

        function void clear();
            foreach (cells[k]) cells[k] = 0;
            foreach (rows[k]) rows[k] = 0;
            foreach (cols[k]) cols[k] = 0;
            n_pat = 0;
            ovf = 0;
        endfunction

        function new();
            clear();
            errors = 0;
            sets_checked = 0;
        endfunction

        function logic [63:0] pairs_of(logic [63:0] c);
            return (c == 0) ? 64'd0 : (c * (c - 1)) / 2;
        endfunction

        function logic [30:0] sat31(logic [63:0] v);
            return (v > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : v[30:0];
        endfunction

        // count one pattern; on a last pattern queue the expected index
        function void note_pattern(t_in x);
            int ra, cb;
            logic [63:0] t1, t2, t3, t4;
            logic [191:0] p, q, num, den, mag;
            bit neg;
            t_out e;
            ra = (x.label_a >= NA) ? NA - 1 : x.label_a;
            cb = (x.label_b >= NB) ? NB - 1 : x.label_b;
            if (n_pat >= CNT_MAX) begin
                ovf = 1;
            end else begin
                n_pat++;
                rows[ra]++;
                cols[cb]++;
                cells[ra*NB + cb]++;
            end
            if (!x.last) return;
            t1 = 0; t2 = 0; t3 = 0;
            foreach (cells[k]) t1 += pairs_of(cells[k]);
            foreach (rows[k]) t2 += pairs_of(rows[k]);
            foreach (cols[k]) t3 += pairs_of(cols[k]);
            t4 = pairs_of(n_pat);
            p = 192'(t1) * 192'(t4);
            q = 192'(t2) * 192'(t3);
            neg = p < q;
            num = neg ? q - p : p - q;
            den = 192'(t2 + t3) * 192'(t4) - (q << 1);
            mag = 0;
            if (den != 0) begin
                mag = (num << 17) / den;
                if (neg && mag > 131072) mag = 131072;
                if (!neg && mag > 65536) mag = 65536;
            end
            e.index_q16 = neg ? -$signed(OUT_W'(mag)) : OUT_W'(mag);
            e.agree_pairs = sat31(t1);
            e.row_pairs = sat31(t2);
            e.col_pairs = sat31(t3);
            e.zero_denominator = (den == 0);
            e.count_overflow = ovf;
            pending.push_back(e);
            clear();
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch in %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_result(t_out r);
            t_out e;
            if (pending.size() == 0) begin
                report("unexpected result", 64'd1, 64'd0);
                return;
            end
            e = pending.pop_front();
            sets_checked++;
            if (r.index_q16 !== e.index_q16)
                report("index_q16", 64'(signed'(r.index_q16)), 64'(signed'(e.index_q16)));
            if (r.agree_pairs !== e.agree_pairs) report("agree_pairs", r.agree_pairs, e.agree_pairs);
            if (r.row_pairs !== e.row_pairs) report("row_pairs", r.row_pairs, e.row_pairs);
            if (r.col_pairs !== e.col_pairs) report("col_pairs", r.col_pairs, e.col_pairs);
            if (r.zero_denominator !== e.zero_denominator)
                report("zero_denominator", r.zero_denominator, e.zero_denominator);
            if (r.count_overflow !== e.count_overflow)
                report("count_overflow", r.count_overflow, e.count_overflow);
        endtask
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_in_valid = 0;
    logic o_in_ready;
    t_in  i_in = '0;
    logic o_out_valid;
    logic i_out_ready = 0;
    t_out o_out;

    ari_scoreboard sb = new();
    bit calm = 0;          // no idling in the last part
    int stall_left = 0;
    int n_sent = 0;

    adjusted_rand_index uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out)
    );

    always #5 i_clk = ~i_clk;

    // result side: check accepted results, stall in bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out);
        if (!i_rst_n) begin
            i_out_ready <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 14) - 1;
            i_out_ready <= 0;
        end else begin
            i_out_ready <= 1;
        end
    end

    // present one request and hold it until accepted; called right after an edge
    task send_pattern(logic [3:0] a, logic [3:0] b, logic lst, bit may_idle);
        t_in x;
        int gap;
        if (may_idle && !calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        x.label_a = a;
        x.label_b = b;
        x.last = lst;
        i_in <= x;
        i_in_valid <= 1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_pattern(x);
        n_sent++;
    endtask

    task release_input();
        i_in_valid <= 0;
    endtask

    task random_set(int len, int ka, int kb);
        int k;
        for (k = 0; k < len; k++)
            send_pattern($urandom_range(0, ka), $urandom_range(0, kb), k == len - 1, 1);
    endtask

    initial begin
        #20ms;
        $display("timeout");
        $display("testbench failed");
        $finish;
    end

    initial begin
        int waitc;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // single pattern: zero denominator
        send_pattern(4'd0, 4'd15, 1, 1);
        // two identical patterns: still zero denominator
        send_pattern(4'd15, 4'd15, 0, 1);
        send_pattern(4'd15, 4'd15, 1, 1);
        // perfect agreement
        send_pattern(4'd0, 4'd3, 0, 1);
        send_pattern(4'd0, 4'd3, 0, 1);
        send_pattern(4'd15, 4'd0, 0, 1);
        send_pattern(4'd15, 4'd0, 1, 1);
        // crossed labels: negative index
        send_pattern(4'd0, 4'd0, 0, 1);
        send_pattern(4'd0, 4'd1, 0, 1);
        send_pattern(4'd1, 4'd0, 0, 1);
        send_pattern(4'd1, 4'd1, 1, 1);
        // mixed extremes
        send_pattern(4'd5, 4'd10, 0, 1);
        send_pattern(4'd10, 4'd5, 0, 1);
        send_pattern(4'd5, 4'd10, 0, 1);
        send_pattern(4'd15, 4'd15, 0, 1);
        send_pattern(4'd0, 4'd0, 1, 1);
        // random data sets, mostly small
        while (n_sent < 16 + 584) begin
            if (n_sent > 16 + 450) calm = 1;
            case ($urandom_range(0, 3))
                0: random_set($urandom_range(1, 6), 15, 15);
                1: random_set($urandom_range(2, 40), 2, 3);
                2: random_set($urandom_range(2, 30), 15, 15);
                default: random_set($urandom_range(2, 20), 1, 1);
            endcase
        end
        release_input();
        calm = 1;
        waitc = 0;
        while (sb.pending.size() != 0 && waitc < 100000) begin
            @(posedge i_clk);
            waitc++;
        end
        repeat (500) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            sb.report("results never arrived", 64'(sb.pending.size()), 64'd0);
        end
        $display("sent %0d patterns in %0d checked data sets, with idle gaps on both sides",
                 n_sent, sb.sets_checked);
        if (sb.errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule
